FILE: rtl/core/utf8_to_utf16_decoder_top_defines.svh
// Assertion macros shared by the UTF-8 to UTF-16 decoder RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef UTF8_TO_UTF16_DECODER_TOP_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define U8U16_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; imported by every module of the block.
package u8u16_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;
    localparam logic [20:0] MAX_POINT        = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST       = 21'h00D800;
    localparam logic [20:0] SURR_LAST        = 21'h00DFFF;
    localparam logic [5:0]  HIGH_SURR_TAG    = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG     = 6'b110111;

    // One decoded job: a run of replacement characters, then optionally a
    // code point that is already range-checked.
    typedef struct packed {
        logic [1:0]  n_bad;
        logic        has_point;
        logic [20:0] point;
    } u8u16_job_t;

endpackage

FILE: rtl/core/u8u16_front.sv
// Front end: accepts UTF-8 beats, tracks the open sequence and builds jobs.
// Depends on u8u16_pkg and the assertion macro header.
`include "utf8_to_utf16_decoder_top_defines.svh"

module u8u16_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_full,
    input  logic [7:0]            byte_in,
    input  logic                  is_last,
    output logic                  push,
    output u8u16_pkg::u8u16_job_t job
);
    import u8u16_pkg::*;

    logic [20:0] partial_point_reg, partial_point_next;
    logic [1:0]  bytes_needed_reg, bytes_needed_next;
    logic [1:0]  bytes_taken_reg, bytes_taken_next;

    logic        accept;
    logic        st_has;
    logic [20:0] st_point;
    logic        st_open;
    logic [20:0] st_bits;
    logic [1:0]  st_extra;
    logic [20:0] cont_point;
    logic [20:0] raw_point;
    logic        raw_has;
    logic [1:0]  raw_bad;

    assign accept     = in_valid && !in_full;
    assign cont_point = {partial_point_reg[14:0], byte_in[5:0]};

    // Decoding of a byte where a lead is expected.
    always_comb
    begin
        st_has   = 1'b0;
        st_point = '0;
        st_open  = 1'b0;
        st_bits  = '0;
        st_extra = '0;
        case (byte_in) inside
            8'b0???????:
            begin
                st_has   = 1'b1;
                st_point = {14'b0, byte_in[6:0]};
            end
            8'b110?????:
            begin
                st_open  = 1'b1;
                st_bits  = {16'b0, byte_in[4:0]};
                st_extra = 2'd1;
            end
            8'b1110????:
            begin
                st_open  = 1'b1;
                st_bits  = {17'b0, byte_in[3:0]};
                st_extra = 2'd2;
            end
            8'b11110???:
            begin
                st_open  = 1'b1;
                st_bits  = {18'b0, byte_in[2:0]};
                st_extra = 2'd3;
            end
            default:
            begin
                st_has   = 1'b1;
                st_point = REPLACEMENT_CHAR;
            end
        endcase
        // A multi-byte lead on the final beat of a string cannot complete.
        if (st_open && is_last)
        begin
            st_open  = 1'b0;
            st_has   = 1'b1;
            st_point = REPLACEMENT_CHAR;
        end
    end

    always_comb
    begin
        partial_point_next = partial_point_reg;
        bytes_needed_next  = bytes_needed_reg;
        bytes_taken_next   = bytes_taken_reg;
        raw_bad            = 2'd0;
        raw_has            = 1'b0;
        raw_point          = '0;
        if (bytes_needed_reg == 2'd0)
        begin
            raw_has   = st_has;
            raw_point = st_point;
            if (st_open)
            begin
                partial_point_next = st_bits;
                bytes_needed_next  = st_extra;
                bytes_taken_next   = 2'd1;
            end
        end
        else if (byte_in[7:6] == 2'b10)
        begin
            if (bytes_needed_reg == 2'd1)
            begin
                raw_has            = 1'b1;
                raw_point          = cont_point;
                partial_point_next = '0;
                bytes_needed_next  = 2'd0;
                bytes_taken_next   = 2'd0;
            end
            else if (is_last)
            begin
                raw_bad            = bytes_taken_reg + 2'd1;
                partial_point_next = '0;
                bytes_needed_next  = 2'd0;
                bytes_taken_next   = 2'd0;
            end
            else
            begin
                partial_point_next = cont_point;
                bytes_needed_next  = bytes_needed_reg - 2'd1;
                bytes_taken_next   = bytes_taken_reg + 2'd1;
            end
        end
        else
        begin
            // Broken sequence: flush what was taken, then treat this byte as a lead.
            raw_bad   = bytes_taken_reg;
            raw_has   = st_has;
            raw_point = st_point;
            if (st_open)
            begin
                partial_point_next = st_bits;
                bytes_needed_next  = st_extra;
                bytes_taken_next   = 2'd1;
            end
            else
            begin
                partial_point_next = '0;
                bytes_needed_next  = 2'd0;
                bytes_taken_next   = 2'd0;
            end
        end
    end

    always_comb
    begin
        job.n_bad     = raw_bad;
        job.has_point = raw_has;
        if (raw_point > MAX_POINT || (raw_point >= SURR_FIRST && raw_point <= SURR_LAST))
        begin
            job.point = REPLACEMENT_CHAR;
        end
        else
        begin
            job.point = raw_point;
        end
    end

    assign push = accept && (raw_has || raw_bad != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_point_reg <= '0;
            bytes_needed_reg  <= '0;
            bytes_taken_reg   <= '0;
        end
        else if (accept)
        begin
            partial_point_reg <= partial_point_next;
            bytes_needed_reg  <= bytes_needed_next;
            bytes_taken_reg   <= bytes_taken_next;
        end
    end

    `U8U16_ASSERT_NOW(a_open_seq_consistent, 1'b1,
        (bytes_needed_reg == 2'd0) == (bytes_taken_reg == 2'd0),
        "front: needed and taken counts disagree on an open sequence")
    `U8U16_ASSERT_NOW(a_seq_len_bound, 1'b1,
        ({1'b0, bytes_needed_reg} + {1'b0, bytes_taken_reg}) <= 3'd4,
        "front: open sequence longer than four bytes")
    `U8U16_ASSERT_NOW(a_lead_is_silent,
        accept && bytes_needed_reg == 2'd0 && byte_in[7:5] == 3'b110 && !is_last,
        !push,
        "front: a two-byte lead pushed a job")

endmodule

FILE: rtl/core/u8u16_queue.sv
// Job queue between the front end and the unit generator.
// Depends on u8u16_pkg for the job type.
module u8u16_queue #(
    parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  u8u16_pkg::u8u16_job_t push_job,
    input  logic                  pop,
    output logic                  full,
    output logic                  head_valid,
    output u8u16_pkg::u8u16_job_t head_job
);
    import u8u16_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8u16_job_t       slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/core/u8u16_back.sv
// Back end: expands one job into output units and holds the output beat.
// Depends on u8u16_pkg and the assertion macro header.
`include "utf8_to_utf16_decoder_top_defines.svh"

module u8u16_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wide_mode,
    input  logic                  head_valid,
    input  u8u16_pkg::u8u16_job_t head_job,
    output logic                  pop,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [20:0]           unit,
    output logic                  end_of_run
);
    import u8u16_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [20:0] unit_reg;
    logic        end_of_run_reg;
    logic [1:0]  idx_reg, idx_next;

    logic        load;
    logic        split;
    logic [2:0]  total;
    logic        last_unit;
    logic [19:0] offset;
    logic [20:0] unit_sel;

    assign load   = head_valid && (!out_valid_reg || !out_stall);
    assign split  = head_job.has_point && !wide_mode && (head_job.point[20:16] != 5'd0);
    assign total  = {1'b0, head_job.n_bad} + {2'b0, head_job.has_point} + {2'b0, split};
    assign last_unit = ({1'b0, idx_reg} + 3'd1) == total;
    assign offset = head_job.point[19:0] - 20'h10000;

    // Replacement characters come first, then the code point or its pair.
    always_comb
    begin
        if (idx_reg < head_job.n_bad)
        begin
            unit_sel = REPLACEMENT_CHAR;
        end
        else if (idx_reg == head_job.n_bad)
        begin
            unit_sel = split ? {5'b0, HIGH_SURR_TAG, offset[19:10]} : head_job.point;
        end
        else
        begin
            unit_sel = {5'b0, LOW_SURR_TAG, offset[9:0]};
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = last_unit ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign pop        = load && last_unit;
    assign out_valid  = out_valid_reg;
    assign unit       = unit_reg;
    assign end_of_run = end_of_run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg       <= unit_sel;
            end_of_run_reg <= last_unit;
        end
    end

    `U8U16_ASSERT_NOW(a_job_stays_at_head, idx_reg != 2'd0, head_valid,
        "back: job left the queue while partly emitted")
    `U8U16_ASSERT_NOW(a_idx_in_job, head_valid, ({1'b0, idx_reg} < total),
        "back: unit index past the end of the job")
    `U8U16_ASSERT_NOW(a_mid_job_output, idx_reg != 2'd0,
        out_valid_reg && !end_of_run_reg,
        "back: mid-job output beat missing or flagged as end of run")
    `U8U16_ASSERT_NEXT(a_idx_advances, load && !last_unit, idx_reg != 2'd0,
        "back: unit index did not advance within a job")

endmodule

FILE: rtl/core/utf8_to_utf16_decoder_top.sv
// UTF-8 to UTF-16 decoder, top level.
//
// Input channel (in_valid, in_stall, byte_in, is_last): one UTF-8 byte per
// beat; is_last marks the final byte of a string. A beat is taken on a rising
// edge with in_valid high and in_stall low.
// Output channel (out_valid, out_stall, unit, end_of_run): one UTF-16 unit, or
// one whole code point when wide mode is set, per beat; end_of_run marks the
// last unit caused by an input byte. A byte may cause zero to four units.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): writes the wide-mode
// bit; cfg_ready is always high. Write it only while the block is idle.
// A byte's job is written to the queue on acceptance and its first unit is then
// loaded into the output register. Throughput: one byte per cycle while each
// byte gives at most one unit and out_stall is low; the output register drains
// one unit per cycle while out_stall is low, so bytes that give several units
// hold the four-entry job queue and raise in_stall once it fills.
// Reset clears the open sequence, the queue, the output beat and wide mode.
// When out_stall is high the output beat holds; the queue keeps taking bytes
// until it is full.
module utf8_to_utf16_decoder_top #(
    parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] unit,
    output logic        end_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import u8u16_pkg::*;

    logic       wide_units_32_reg;
    logic       q_full;
    logic       q_push;
    u8u16_job_t q_push_job;
    logic       q_pop;
    logic       q_head_valid;
    u8u16_job_t q_head_job;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_units_32_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            wide_units_32_reg <= cfg_data;
        end
    end

    u8u16_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_full  (q_full),
        .byte_in  (byte_in),
        .is_last  (is_last),
        .push     (q_push),
        .job      (q_push_job)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    u8u16_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wide_mode  (wide_units_32_reg),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .unit       (unit),
        .end_of_run (end_of_run)
    );

endmodule
